FILE: rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros shared by the checker modules
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, gated off while reset is asserted
`define CREF_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: check failed");

// Next-cycle implication, gated off while reset is asserted
`define CREF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: check failed");

`endif

FILE: rtl/cref_pkg.sv
// ---------------------------------------------------------------------------
// cref_pkg
// Shared constants for the character reference decoder: stream layout,
// reference form codes and result limits.
// ---------------------------------------------------------------------------
`default_nettype none

package cref_pkg;

  // Input stream tdata layout (lowest field first)
  localparam int CHAR_W       = 8;
  localparam int INDEX_W      = 8;
  localparam int ENTRY_NAME_W = 63;
  localparam int LEN_W        = 4;
  localparam int CODE_W       = 16;
  localparam int CHAR_LO      = 0;
  localparam int INDEX_LO     = CHAR_LO + CHAR_W;
  localparam int NAME_LO      = INDEX_LO + INDEX_W;
  localparam int LEN_LO       = NAME_LO + ENTRY_NAME_W;
  localparam int CODE_LO      = LEN_LO + LEN_W;
  localparam int IN_FIELDS_W  = CODE_LO + CODE_W;
  localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;

  // Result stream layout
  localparam int VALUE_W      = 32;
  localparam int FORM_W       = 2;
  localparam int OUT_TDATA_W  = VALUE_W;
  localparam int OUT_TUSER_W  = FORM_W + 1;

  // Name characters are 7-bit ASCII
  localparam int NCHAR_W      = 7;

  // Reference forms
  typedef logic [FORM_W-1:0] form_t;
  localparam form_t FORM_HEX  = 2'd0;
  localparam form_t FORM_DEC  = 2'd1;
  localparam form_t FORM_NAME = 2'd2;

  localparam logic [VALUE_W-1:0] NO_CODE   = 32'hFFFF_FFFF;
  localparam logic [VALUE_W-1:0] DEC_LIMIT = 32'h7FFF_FFFF;

endpackage

`default_nettype wire

FILE: rtl/cref_ram.sv
// ---------------------------------------------------------------------------
// cref_ram
// Generic single-write, single-read RAM with a registered read port.
// ---------------------------------------------------------------------------
`default_nettype none

module cref_ram #(
  parameter  int WIDTH = 8,
  parameter  int DEPTH = 16,
  localparam int AW    = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write one word, read one word a cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

FILE: rtl/char_reference_decoder_top.sv
// ---------------------------------------------------------------------------
// char_reference_decoder_top
// Decodes one markup character reference ("#x1F", "#65", "amp"), one
// character per item, and emits one result per terminator item.
// ---------------------------------------------------------------------------
// After reset a clearing pass empties the name table, writing every slot
// with in_tready low. A table write item completes when it is accepted.
// A reference character is accepted, then makes one pass through the
// shared 36-bit adder (S_CHAR); a decimal digit makes a second pass in
// S_DEC2, since x10+d needs two adder passes. A terminator of a hex or
// decimal reference goes through S_END and S_OUT to the result register
// once it is free; a named reference first walks the name table RAM in
// S_LOOK, one slot a cycle, as the RAM has a single read port. The result
// register frees the input side: a new item is taken while a result still waits for out_tready.
`default_nettype none

module char_reference_decoder_top #(
  parameter int TABLE_DEPTH = 256,
  parameter int NAME_CHARS  = 9
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  // in_tdata: char_byte, entry_index, entry_name, entry_name_len, entry_code
  input  wire logic [cref_pkg::IN_TDATA_W-1:0]  in_tdata,
  // in_tuser: mode
  input  wire logic [0:0]                     in_tuser,
  input  wire logic                           in_tlast,
  input  wire logic                           in_tvalid,
  output logic                                in_tready,
  // out_tdata: code_value
  output logic [cref_pkg::OUT_TDATA_W-1:0]    out_tdata,
  // out_tuser: form, matched
  output logic [cref_pkg::OUT_TUSER_W-1:0]    out_tuser,
  output logic                                out_tvalid,
  input  wire logic                           out_tready
);

  import cref_pkg::*;

  localparam int AW      = $clog2(TABLE_DEPTH);
  localparam int NAME_W  = NCHAR_W * NAME_CHARS;
  localparam int ENTRY_W = NAME_W + LEN_W + CODE_W;
  localparam int ADD_W   = VALUE_W + 4;

  // Sequencer states
  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_CHAR  = 3'd2;
  localparam logic [2:0] S_DEC2  = 3'd3;
  localparam logic [2:0] S_END   = 3'd4;
  localparam logic [2:0] S_LOOK  = 3'd5;
  localparam logic [2:0] S_OUT   = 3'd6;

  localparam logic [7:0] CH_HASH = 8'h23;
  localparam logic [7:0] CH_X    = 8'h78;

  function automatic logic [4:0] hex_digit(input logic [7:0] ch);
    logic [4:0] r;
    r = 5'h10;
    if (ch >= 8'h30 && ch <= 8'h39) begin
      r = {1'b0, ch[3:0]};
    end else if ((ch >= 8'h61 && ch <= 8'h66) || (ch >= 8'h41 && ch <= 8'h46)) begin
      r = {1'b0, ch[3:0] + 4'd9};
    end
    return r;
  endfunction

  logic [2:0]         state_r, state_nxt;
  logic [AW-1:0]      clr_r, clr_nxt;
  logic [AW:0]        walk_r, walk_nxt;
  logic               rvalid_r, rvalid_nxt;
  logic [1:0]         pos_r, pos_nxt;
  form_t              form_r, form_nxt;
  logic [VALUE_W-1:0] acc_r, acc_nxt;
  logic               stop_r, stop_nxt;
  logic               err_r, err_nxt;
  logic [NAME_W-1:0]  nbuf_r, nbuf_nxt;
  logic [LEN_W-1:0]   nlen_r, nlen_nxt;
  logic               out_valid_r, out_valid_nxt;

  logic [7:0]         ch_r, ch_nxt;
  logic [ADD_W-1:0]   tmp_r, tmp_nxt;
  logic [VALUE_W-1:0] res_code_r, res_code_nxt;
  form_t              res_form_r, res_form_nxt;
  logic               res_match_r, res_match_nxt;
  logic [VALUE_W-1:0] out_code_r, out_code_nxt;
  form_t              out_form_r, out_form_nxt;
  logic               out_match_r, out_match_nxt;

  logic               in_fire;
  logic [4:0]         hex_d;
  logic               is_dec;
  logic [ADD_W-1:0]   add_a, add_b, add_sum;
  logic               issuing;
  logic               hit;
  form_t              form_end;

  logic               tbl_we;
  logic [AW-1:0]      tbl_waddr;
  logic [ENTRY_W-1:0] tbl_wdata;
  logic [ENTRY_W-1:0] tbl_rdata;
  logic [31:0]        idx_ext;
  logic [NAME_W-1:0]  rd_name;
  logic [LEN_W-1:0]   rd_len;
  logic [CODE_W-1:0]  rd_code;

  assign in_tready = (state_r == S_IDLE);
  assign in_fire   = in_tvalid && in_tready;

  // Name table: written by mode 1 items or by the clearing pass
  assign idx_ext = 32'(in_tdata[INDEX_LO +: INDEX_W]);

  always_comb begin
    tbl_we    = 1'b0;
    tbl_waddr = clr_r;
    tbl_wdata = '0;
    if (state_r == S_CLEAR) begin
      tbl_we = 1'b1;
    end else if (in_fire && in_tuser[0]) begin
      tbl_we    = (idx_ext < 32'(TABLE_DEPTH));
      tbl_waddr = idx_ext[AW-1:0];
      tbl_wdata = {in_tdata[CODE_LO +: CODE_W], in_tdata[LEN_LO +: LEN_W],
                   in_tdata[NAME_LO +: NAME_W]};
    end
  end

  cref_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk     (clk),
    .wr_en   (tbl_we),
    .wr_addr (tbl_waddr),
    .wr_data (tbl_wdata),
    .rd_addr (walk_r[AW-1:0]),
    .rd_data (tbl_rdata)
  );

  assign rd_name = tbl_rdata[NAME_W-1:0];
  assign rd_len  = tbl_rdata[NAME_W +: LEN_W];
  assign rd_code = tbl_rdata[NAME_W + LEN_W +: CODE_W];

  // Compare the slot just read against the collected name
  always_comb begin
    hit = (rd_len == nlen_r);
    for (int i = 0; i < NAME_CHARS; i++) begin
      if (LEN_W'(i) < nlen_r &&
          rd_name[i*NCHAR_W +: NCHAR_W] != nbuf_r[i*NCHAR_W +: NCHAR_W]) begin
        hit = 1'b0;
      end
    end
  end

  // Character classes of the held character
  assign hex_d  = hex_digit(ch_r);
  assign is_dec = (ch_r >= 8'h30 && ch_r <= 8'h39);

  // Shared adder: hex shift-in, decimal x8+x2, then +digit
  always_comb begin
    add_a = {acc_r, 4'd0};
    add_b = {32'd0, hex_d[3:0]};
    if (state_r == S_DEC2) begin
      add_a = tmp_r;
      add_b = {32'd0, ch_r[3:0]};
    end else if (form_r == FORM_DEC) begin
      add_a = {1'b0, acc_r, 3'd0};
      add_b = {3'd0, acc_r, 1'b0};
    end
  end
  assign add_sum = add_a + add_b;

  assign issuing  = (walk_r < (AW+1)'(TABLE_DEPTH));
  assign form_end = (pos_r == 2'd0) ? FORM_NAME : form_r;

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    clr_nxt       = clr_r;
    walk_nxt      = walk_r;
    rvalid_nxt    = 1'b0;
    pos_nxt       = pos_r;
    form_nxt      = form_r;
    acc_nxt       = acc_r;
    stop_nxt      = stop_r;
    err_nxt       = err_r;
    nbuf_nxt      = nbuf_r;
    nlen_nxt      = nlen_r;
    out_valid_nxt = out_valid_r && !out_tready;
    ch_nxt        = ch_r;
    tmp_nxt       = tmp_r;
    res_code_nxt  = res_code_r;
    res_form_nxt  = res_form_r;
    res_match_nxt = res_match_r;
    out_code_nxt  = out_code_r;
    out_form_nxt  = out_form_r;
    out_match_nxt = out_match_r;

    unique case (state_r)
      S_CLEAR: begin
        clr_nxt = clr_r + 1'b1;
        if (clr_r == AW'(TABLE_DEPTH - 1)) begin
          state_nxt = S_IDLE;
        end
      end

      S_IDLE: begin
        // Table writes finish here; characters go on to the adder, terminators to S_END
        if (in_fire && !in_tuser[0]) begin
          ch_nxt    = in_tdata[CHAR_LO +: CHAR_W];
          state_nxt = in_tlast ? S_END : S_CHAR;
        end
      end

      S_CHAR: begin
        state_nxt = S_IDLE;
        pos_nxt   = (pos_r == 2'd2) ? 2'd2 : pos_r + 2'd1;
        if (pos_r == 2'd0 && ch_r == CH_HASH) begin
          form_nxt = FORM_DEC;
        end else if (form_r == FORM_DEC && pos_r == 2'd1 && ch_r == CH_X) begin
          form_nxt = FORM_HEX;
        end else if (pos_r != 2'd0 && form_r == FORM_HEX) begin
          if (!stop_r) begin
            if (hex_d[4]) begin
              stop_nxt = 1'b1;
            end else begin
              acc_nxt = add_sum[VALUE_W-1:0];
            end
          end
        end else if (pos_r != 2'd0 && form_r == FORM_DEC) begin
          if (!err_r) begin
            if (is_dec) begin
              tmp_nxt   = add_sum;
              state_nxt = S_DEC2;
            end else begin
              err_nxt = 1'b1;
            end
          end
        end else begin
          // Append to the name; too long or non-ASCII never matches
          form_nxt = FORM_NAME;
          if (nlen_r >= LEN_W'(NAME_CHARS) || ch_r[7]) begin
            err_nxt = 1'b1;
          end else begin
            for (int i = 0; i < NAME_CHARS; i++) begin
              if (nlen_r == LEN_W'(i)) begin
                nbuf_nxt[i*NCHAR_W +: NCHAR_W] = ch_r[NCHAR_W-1:0];
              end
            end
            nlen_nxt = nlen_r + 1'b1;
          end
        end
      end

      S_DEC2: begin
        state_nxt = S_IDLE;
        if (add_sum > {4'd0, DEC_LIMIT}) begin
          err_nxt = 1'b1;
        end else begin
          acc_nxt = add_sum[VALUE_W-1:0];
        end
      end

      S_END: begin
        res_form_nxt  = form_end;
        res_code_nxt  = NO_CODE;
        res_match_nxt = 1'b0;
        state_nxt     = S_OUT;
        if (form_end == FORM_HEX) begin
          res_code_nxt  = acc_r;
          res_match_nxt = 1'b1;
        end else if (form_end == FORM_DEC) begin
          if (!err_r && pos_r == 2'd2) begin
            res_code_nxt  = acc_r;
            res_match_nxt = 1'b1;
          end
        end else if (!err_r && nlen_r != '0) begin
          walk_nxt  = '0;
          state_nxt = S_LOOK;
        end
      end

      S_LOOK: begin
        // Issue one slot a cycle, compare the slot read last cycle
        rvalid_nxt = issuing;
        if (issuing) begin
          walk_nxt = walk_r + 1'b1;
        end
        if (rvalid_r && hit) begin
          res_code_nxt  = {{(VALUE_W-CODE_W){1'b0}}, rd_code};
          res_match_nxt = 1'b1;
          state_nxt     = S_OUT;
        end else if (!rvalid_r && !issuing) begin
          state_nxt = S_OUT;
        end
      end

      S_OUT: begin
        // Load the result register once it is free, then start afresh
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_code_nxt  = res_code_r;
          out_form_nxt  = res_form_r;
          out_match_nxt = res_match_r;
          pos_nxt       = '0;
          form_nxt      = FORM_HEX;
          acc_nxt       = '0;
          stop_nxt      = 1'b0;
          err_nxt       = 1'b0;
          nbuf_nxt      = '0;
          nlen_nxt      = '0;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control and reference state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      walk_r      <= '0;
      rvalid_r    <= 1'b0;
      pos_r       <= '0;
      form_r      <= FORM_HEX;
      acc_r       <= '0;
      stop_r      <= 1'b0;
      err_r       <= 1'b0;
      nbuf_r      <= '0;
      nlen_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      walk_r      <= walk_nxt;
      rvalid_r    <= rvalid_nxt;
      pos_r       <= pos_nxt;
      form_r      <= form_nxt;
      acc_r       <= acc_nxt;
      stop_r      <= stop_nxt;
      err_r       <= err_nxt;
      nbuf_r      <= nbuf_nxt;
      nlen_r      <= nlen_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    ch_r        <= ch_nxt;
    tmp_r       <= tmp_nxt;
    res_code_r  <= res_code_nxt;
    res_form_r  <= res_form_nxt;
    res_match_r <= res_match_nxt;
    out_code_r  <= out_code_nxt;
    out_form_r  <= out_form_nxt;
    out_match_r <= out_match_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_code_r;
  assign out_tuser  = {out_match_r, out_form_r};

endmodule

`default_nettype wire

FILE: rtl/cref_checker.sv
// ---------------------------------------------------------------------------
// cref_checker
// Port-level checks on the character reference decoder, bound to the top.
// ---------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module cref_checker (
  input wire logic                           clk,
  input wire logic                           rst_n,
  input wire logic [cref_pkg::IN_TDATA_W-1:0]  in_tdata,
  input wire logic [0:0]                     in_tuser,
  input wire logic                           in_tlast,
  input wire logic                           in_tvalid,
  input wire logic                           in_tready,
  input wire logic [cref_pkg::OUT_TDATA_W-1:0] out_tdata,
  input wire logic [cref_pkg::OUT_TUSER_W-1:0] out_tuser,
  input wire logic                           out_tvalid,
  input wire logic                           out_tready
);

  import cref_pkg::*;

  logic unused_in;
  assign unused_in = ^{in_tdata, in_tuser, in_tlast, in_tvalid};

  // A stalled result holds
  `CREF_ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tuser))

  // An unmatched result carries the no-code value
  `CREF_ASSERT_NOW(a_nomatch_code, clk, rst_n, out_tvalid && !out_tuser[FORM_W], out_tdata == NO_CODE)

  // A matched name resolves to a 16-bit code
  `CREF_ASSERT_NOW(a_name_code, clk, rst_n, out_tvalid && out_tuser[FORM_W] && (out_tuser[FORM_W-1:0] == FORM_NAME), out_tdata[VALUE_W-1:CODE_W] == '0)

  // A matched decimal never exceeds the signed 32-bit limit
  `CREF_ASSERT_NOW(a_dec_limit, clk, rst_n, out_tvalid && out_tuser[FORM_W] && (out_tuser[FORM_W-1:0] == FORM_DEC), out_tdata <= DEC_LIMIT)

  // The table clearing pass keeps the input closed right after reset
  `CREF_ASSERT_NOW(a_clear_closed, clk, rst_n, $past(!rst_n), !in_tready)

endmodule

bind char_reference_decoder_top cref_checker u_cref_checker (.*);

`default_nettype wire

FILE: tb/tb_char_reference_decoder_top.sv
// ---------------------------------------------------------------------------
// tb_char_reference_decoder_top
// Self-checking bench for the character reference decoder. A queue of
// character and table-write items feeds a bursty stream driver. A local
// decoder model predicts each terminator's result. A monitor behind a
// stalling receiver compares every result field by field with the oldest
// prediction.
// ---------------------------------------------------------------------------
`default_nettype none

module tb_char_reference_decoder_top;
  timeunit 1ns;
  timeprecision 1ps;

  import cref_pkg::*;

  localparam int TABLE_DEPTH  = 256;
  localparam int NAME_CHARS   = 9;
  localparam int RANDOM_ITEMS = 1130;
  localparam int QUIET_LIMIT  = 8 * (TABLE_DEPTH + 16);
  localparam int TAIL_CYCLES  = TABLE_DEPTH + 40;

  localparam logic [7:0] CH_HASH = 8'h23;
  localparam logic [7:0] CH_X    = 8'h78;
  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] CH_NINE = 8'h39;

  typedef struct packed {
    logic        mode;
    logic [7:0]  char_byte;
    logic        last;
    logic [7:0]  entry_index;
    logic [62:0] entry_name;
    logic [3:0]  entry_len;
    logic [15:0] entry_code;
  } char_item_t;

  typedef struct packed {
    logic [31:0] value;
    form_t       form;
    logic        matched;
  } code_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic [IN_TDATA_W-1:0] in_tdata = '0;
  logic [0:0] in_tuser = '0;
  logic in_tlast = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic [OUT_TUSER_W-1:0] out_tuser;
  logic out_tvalid;
  logic out_tready = 1'b0;

  char_reference_decoder_top #(
    .TABLE_DEPTH(TABLE_DEPTH),
    .NAME_CHARS (NAME_CHARS)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .in_tlast  (in_tlast),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready)
  );

  always #5 clk = ~clk;

  // Stimulus and expected results
  char_item_t   char_items[$];
  code_result_t expected_codes[$];
  logic [66:0]  name_pool[$];
  string hex_set  = "0123456789abcdefABCDEF";
  string stop_set = "g;# zX";
  string junk_set = "+- a.";

  // Decoder model state
  logic [3:0]  ref_pos = '0;
  form_t       cur_form = FORM_HEX;
  logic [31:0] acc = '0;
  logic        hex_stopped = 1'b0;
  logic        bad_ref = 1'b0;
  logic [62:0] name_buf = '0;
  logic [4:0]  name_len = '0;
  logic [62:0] tbl_name [TABLE_DEPTH];
  logic [3:0]  tbl_len  [TABLE_DEPTH];
  logic [15:0] tbl_code [TABLE_DEPTH];

  int fail_count  = 0;
  int items_taken = 0;
  int quiet_cycles = 0;
  int burst_left = 0;
  int gap_left = 0;
  logic [9:0] stall_phase = '0;
  char_item_t drv_item;
  code_result_t got_code, want_code;

  // -------------------------------------------------------------------------
  // Decoder model
  // -------------------------------------------------------------------------
  function automatic int hex_val(input logic [7:0] ch);
    if (ch >= "0" && ch <= "9") return int'(ch) - 48;
    if (ch >= "a" && ch <= "f") return int'(ch) - 87;
    if (ch >= "A" && ch <= "F") return int'(ch) - 55;
    return -1;
  endfunction

  task automatic add_name_char(input logic [7:0] ch);
    if (name_len >= 5'(NAME_CHARS) || ch[7]) begin
      bad_ref = 1'b1;
    end else begin
      name_buf[7*name_len +: 7] = ch[6:0];
      name_len++;
    end
  endtask

  task automatic decode_char_item(input char_item_t it);
    code_result_t res;
    logic [3:0]   pos;
    logic [62:0]  mask;
    logic [63:0]  dec_next;
    int           dv;
    bit           found;
    if (it.mode) begin
      // table write leaves the reference in progress alone
      tbl_name[it.entry_index] = it.entry_name;
      tbl_len[it.entry_index]  = it.entry_len;
      tbl_code[it.entry_index] = it.entry_code;
    end else if (!it.last) begin
      pos = ref_pos;
      if (ref_pos != 4'd15) ref_pos++;
      dv = hex_val(it.char_byte);
      if (pos == 4'd0) begin
        if (it.char_byte == CH_HASH) cur_form = FORM_DEC;
        else begin
          cur_form = FORM_NAME;
          add_name_char(it.char_byte);
        end
      end else if (cur_form == FORM_DEC && pos == 4'd1 && it.char_byte == CH_X) begin
        cur_form = FORM_HEX;
      end else if (cur_form == FORM_HEX) begin
        // first non-hex character freezes the value
        if (!hex_stopped) begin
          if (dv < 0) hex_stopped = 1'b1;
          else acc = {acc[27:0], dv[3:0]};
        end
      end else if (cur_form == FORM_DEC) begin
        if (!bad_ref) begin
          if (it.char_byte >= CH_ZERO && it.char_byte <= CH_NINE) begin
            dec_next = {32'd0, acc} * 64'd10 + 64'(it.char_byte - CH_ZERO);
            if (dec_next > 64'(DEC_LIMIT)) bad_ref = 1'b1;
            else acc = dec_next[31:0];
          end else begin
            bad_ref = 1'b1;
          end
        end
      end else begin
        add_name_char(it.char_byte);
      end
    end else begin
      // terminator closes the reference
      if (ref_pos == 4'd0) cur_form = FORM_NAME;
      res.value   = NO_CODE;
      res.form    = cur_form;
      res.matched = 1'b0;
      if (cur_form == FORM_HEX) begin
        res.value   = acc;
        res.matched = 1'b1;
      end else if (cur_form == FORM_DEC) begin
        if (!bad_ref && ref_pos >= 4'd2) begin
          res.value   = acc;
          res.matched = 1'b1;
        end
      end else if (!bad_ref && name_len != 5'd0) begin
        mask  = (63'd1 << (7 * name_len)) - 63'd1;
        found = 1'b0;
        for (int i = 0; i < TABLE_DEPTH; i++) begin
          if (!found && {1'b0, tbl_len[i]} == name_len && (tbl_name[i] & mask) == name_buf) begin
            found       = 1'b1;
            res.value   = {16'd0, tbl_code[i]};
            res.matched = 1'b1;
          end
        end
      end
      expected_codes.push_back(res);
      ref_pos     = '0;
      cur_form    = FORM_HEX;
      acc         = '0;
      hex_stopped = 1'b0;
      bad_ref     = 1'b0;
      name_buf    = '0;
      name_len    = '0;
    end
  endtask

  // -------------------------------------------------------------------------
  // Stimulus helpers
  // -------------------------------------------------------------------------
  function automatic char_item_t char_of(input logic [7:0] ch, input logic lst);
    char_item_t it;
    it.mode        = 1'b0;
    it.char_byte   = ch;
    it.last        = lst;
    it.entry_index = 8'($urandom);
    it.entry_name  = 63'({$urandom, $urandom});
    it.entry_len   = 4'($urandom);
    it.entry_code  = 16'($urandom);
    return it;
  endfunction

  function automatic char_item_t entry_of(input logic [7:0] idx, input logic [62:0] nm,
                                          input logic [3:0] nl, input logic [15:0] code);
    char_item_t it;
    it.mode        = 1'b1;
    it.char_byte   = 8'($urandom);
    it.last        = 1'($urandom);
    it.entry_index = idx;
    it.entry_name  = nm;
    it.entry_len   = nl;
    it.entry_code  = code;
    return it;
  endfunction

  function automatic logic [62:0] pack_name(input string s);
    logic [62:0] nm;
    logic [7:0]  c;
    nm = '0;
    for (int i = 0; i < s.len() && i < 9; i++) begin
      c = s[i];
      nm[7*i +: 7] = c[6:0];
    end
    return nm;
  endfunction

  task automatic add_char(input logic [7:0] ch);
    char_items.push_back(char_of(ch, 1'b0));
  endtask

  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++) add_char(s[i]);
  endtask

  task automatic end_ref();
    char_items.push_back(char_of(8'($urandom), 1'b1));
  endtask

  task automatic push_entry(input int idx, input string nm, input int code);
    char_items.push_back(entry_of(8'(idx), pack_name(nm), 4'(nm.len()), 16'(code)));
    name_pool.push_back({4'(nm.len()), pack_name(nm)});
  endtask

  // -------------------------------------------------------------------------
  // Stream driver: bursts of items with random gaps
  // -------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        decode_char_item(drv_item);
        items_taken++;
      end
      if (!in_tvalid || in_tready) begin
        if (gap_left != 0) begin
          gap_left--;
          in_tvalid <= 1'b0;
        end else if (char_items.size() != 0) begin
          drv_item = char_items.pop_front();
          in_tdata <= IN_TDATA_W'({drv_item.entry_code, drv_item.entry_len,
                                   drv_item.entry_name, drv_item.entry_index,
                                   drv_item.char_byte});
          in_tuser  <= drv_item.mode;
          in_tlast  <= drv_item.last;
          in_tvalid <= 1'b1;
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 24);
            gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
          end else begin
            burst_left--;
          end
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // -------------------------------------------------------------------------
  // Receiver: rotate through always-ready, light, heavy and long stalls
  // -------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      stall_phase <= stall_phase + 10'd1;
      case (stall_phase[9:8])
        2'd0:    out_tready <= 1'b1;
        2'd1:    out_tready <= ($urandom_range(0, 3) != 0);
        2'd2:    out_tready <= ($urandom_range(0, 1) == 0);
        default: out_tready <= (stall_phase[3:0] > 4'd11);
      endcase
    end
  end

  // -------------------------------------------------------------------------
  // Result monitor
  // -------------------------------------------------------------------------
  task automatic note_failure(input string what, input code_result_t want,
                              input code_result_t got);
    if (fail_count < 10)
      $display("%s: expected value %h form %0d matched %0b, got value %h form %0d matched %0b",
               what, want.value, want.form, want.matched, got.value, got.form, got.matched);
    fail_count++;
  endtask

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      got_code.value   = out_tdata;
      got_code.form    = out_tuser[FORM_W-1:0];
      got_code.matched = out_tuser[FORM_W];
      if (expected_codes.size() == 0) begin
        note_failure("result with none pending", '0, got_code);
      end else begin
        want_code = expected_codes.pop_front();
        if (want_code !== got_code) note_failure("result differs", want_code, got_code);
      end
    end
  end

  // -------------------------------------------------------------------------
  // Watchdog on cycles with no handshake on either side
  // -------------------------------------------------------------------------
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk);
    $display("char_reference_decoder_top: mismatch");
    $finish;
  end

  // -------------------------------------------------------------------------
  // Main sequence
  // -------------------------------------------------------------------------
  initial begin
    int          kind;
    int          n;
    int          pick;
    int          total;
    int          stop_at;
    logic [62:0] nm;
    logic [3:0]  nl;
    logic [66:0] ent;

    for (int i = 0; i < TABLE_DEPTH; i++) begin
      tbl_name[i] = '0;
      tbl_len[i]  = '0;
      tbl_code[i] = '0;
    end

    // Table: duplicate name (lowest slot wins), full-length name, junk
    // above the name length, an over-long length and an empty slot
    push_entry(200, "amp", 1);
    push_entry(0, "amp", 38);
    push_entry(255, "abcdefghi", 16'hFFFF);
    char_items.push_back(entry_of(8'd17, pack_name("lt") | 63'h7FFF_0000_0000_0000,
                                  4'd2, 16'd60));
    char_items.push_back(entry_of(8'd3, pack_name("quotquotq"), 4'd12, 16'd34));
    char_items.push_back(entry_of(8'd4, pack_name("nbsp"), 4'd0, 16'd160));

    // Hex: plain, empty, wrapping, stopped scan, long run of leading zeros
    add_text("#x1F"); end_ref();
    add_text("#x"); end_ref();
    add_text("#xdeadBEEF12"); end_ref();
    add_text("#x12g34"); end_ref();
    add_text("#x0000000000000000041"); end_ref();
    // Decimal: values, limit, over limit, sign, space, letters, bare hash
    add_text("#65"); end_ref();
    add_text("#0"); end_ref();
    add_text("#2147483647"); end_ref();
    add_text("#2147483648"); end_ref();
    add_text("#-5"); end_ref();
    add_text("# 5"); end_ref();
    add_text("#1x"); end_ref();
    add_text("#X1"); end_ref();
    add_text("#"); end_ref();
    // Terminator alone gives an empty name
    end_ref();
    // Names: hits, too long, bad slots, miss, high byte, single x
    add_text("amp"); end_ref();
    add_text("lt"); end_ref();
    add_text("abcdefghi"); end_ref();
    add_text("abcdefghij"); end_ref();
    add_text("quotquotq"); end_ref();
    add_text("nbsp"); end_ref();
    add_text("ampx"); end_ref();
    add_text("a"); add_char(8'hE9); end_ref();
    add_text("x"); end_ref();
    // Table write in the middle of a reference
    add_text("#4"); push_entry(9, "fo", 70); add_text("2"); end_ref();
    add_text("fo"); end_ref();

    // Random part: mostly well-formed references with random content
    stop_at = char_items.size() + RANDOM_ITEMS;
    while (char_items.size() < stop_at) begin
      kind = $urandom_range(0, 99);
      if (kind < 8) begin
        if ($urandom_range(0, 6) != 0) begin
          nl = 4'($urandom_range(1, NAME_CHARS));
          nm = '0;
          for (int i = 0; i < int'(nl); i++) nm[7*i +: 7] = 7'h61 + 7'($urandom_range(0, 4));
          char_items.push_back(entry_of(8'($urandom), nm, nl, 16'($urandom)));
          name_pool.push_back({nl, nm});
          if (name_pool.size() > 24) void'(name_pool.pop_front());
        end else begin
          char_items.push_back(entry_of(8'($urandom), 63'({$urandom, $urandom}),
                                        4'($urandom), 16'($urandom)));
        end
      end else if (kind < 30) begin
        add_text("#x");
        n = $urandom_range(0, 10);
        for (int i = 0; i < n; i++) add_char(hex_set[$urandom_range(0, 21)]);
        if ($urandom_range(0, 4) == 0) begin
          add_char(stop_set[$urandom_range(0, 5)]);
          n = $urandom_range(0, 4);
          for (int i = 0; i < n; i++) add_char(8'($urandom));
        end
        end_ref();
      end else if (kind < 52) begin
        add_char(CH_HASH);
        pick = $urandom_range(0, 19);
        if (pick < 12) begin
          n = $urandom_range(1, 7);
          for (int i = 0; i < n; i++) add_char(CH_ZERO + 8'($urandom_range(0, 9)));
        end else if (pick < 17) begin
          add_text("21474836");
          for (int i = 0; i < 2; i++) add_char(CH_ZERO + 8'($urandom_range(0, 9)));
        end else if (pick < 19) begin
          n = $urandom_range(0, 4);
          for (int i = 0; i < n; i++) add_char(CH_ZERO + 8'($urandom_range(0, 9)));
          add_char(junk_set[$urandom_range(0, 4)]);
          n = $urandom_range(0, 3);
          for (int i = 0; i < n; i++) add_char(CH_ZERO + 8'($urandom_range(0, 9)));
        end else begin
          for (int i = 0; i < 11; i++) add_char(CH_ZERO + 8'($urandom_range(0, 9)));
        end
        end_ref();
      end else if (kind < 80 && name_pool.size() != 0) begin
        ent = name_pool[$urandom_range(0, name_pool.size() - 1)];
        nl  = ent[66:63];
        nm  = ent[62:0];
        // occasional near miss: one character short or one too many
        if ($urandom_range(0, 9) == 0 && nl > 4'd1) nl--;
        for (int i = 0; i < int'(nl); i++) add_char({1'b0, nm[7*i +: 7]});
        if ($urandom_range(0, 9) == 0) add_char(8'h61);
        end_ref();
      end else if (kind < 90) begin
        n = $urandom_range(1, 11);
        for (int i = 0; i < n; i++) add_char(8'h61 + 8'($urandom_range(0, 25)));
        end_ref();
      end else begin
        if ($urandom_range(0, 1) == 0) add_char(CH_HASH);
        n = $urandom_range(0, 17);
        for (int i = 0; i < n; i++) add_char(8'($urandom));
        end_ref();
      end
    end
    total = char_items.size();

    // Reset, then let the stream run to completion
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    while (items_taken != total) @(posedge clk);
    while (expected_codes.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (fail_count == 0 && expected_codes.size() == 0) begin
      $display("char_reference_decoder_top: match");
    end else begin
      $display("char_reference_decoder_top: mismatch");
    end
    $finish;
  end

endmodule

`default_nettype wire
